/* hw/rtl/iis_pkg.sv */
`timescale 1ns / 1ps

package iis_pkg;

    localparam int CFG_BITS = 11;
    localparam int SUM_BITS = 28;
    localparam logic [CFG_BITS-1:0] CFG_SIZE_RESET = 11'd1024;

    typedef enum logic [0:0] {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic row_zero;
        logic row_end;
        logic frame_end;
    } t_flags;

endpackage

/* hw/rtl/iis_pix_if.sv */
`timescale 1ns / 1ps

interface iis_pix_if #(
    parameter int PIXEL_BITS = 8
);
    logic                  valid;
    logic                  ready;
    logic [PIXEL_BITS-1:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

/* hw/rtl/iis_sum_if.sv */
`timescale 1ns / 1ps

interface iis_sum_if;
    import iis_pkg::*;

    logic                valid;
    logic                ready;
    logic [SUM_BITS-1:0] integral_sum;
    logic                row_end;
    logic                frame_end;

    modport source (output valid, output integral_sum, output row_end, output frame_end,
                    input ready);
    modport sink   (input valid, input integral_sum, input row_end, input frame_end,
                    output ready);
endinterface

/* hw/rtl/iis_front.sv */
`timescale 1ns / 1ps

module iis_front #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int PIXEL_BITS = 8,
    parameter int CW         = $clog2(MAX_WIDTH),
    parameter int RSW        = CW + PIXEL_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  iis_pkg::t_cfg_idx             i_cfg_idx,
    input  logic [iis_pkg::CFG_BITS-1:0]  i_cfg_data,
    input  logic                          i_pix_valid,
    input  logic [PIXEL_BITS-1:0]         i_pix,
    input  logic                          i_q_full,
    output logic                          o_pix_ready,
    output logic                          o_push,
    output logic [RSW-1:0]                o_rs,
    output logic [CW-1:0]                 o_col,
    output iis_pkg::t_flags               o_flags
);
    import iis_pkg::*;

    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int WWB = $clog2(MAX_WIDTH + 1);
    localparam int HWB = $clog2(MAX_HEIGHT + 1);
    localparam int CWW = (WWB > CFG_BITS) ? WWB : CFG_BITS;
    localparam int CHW = (HWB > CFG_BITS) ? HWB : CFG_BITS;

    logic [CFG_BITS-1:0] r_fw, r_fh;
    logic [CW-1:0]       r_col, n_col;
    logic [RW-1:0]       r_row, n_row;
    logic [RSW-1:0]      r_rs, n_rs;
    logic [CWW-1:0]      w_eff;
    logic [CHW-1:0]      h_eff;
    logic                last_col, last_row, push;
    logic [RSW-1:0]      rs_cur;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw <= CFG_SIZE_RESET;
            r_fh <= CFG_SIZE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FRAME_WIDTH:  r_fw <= i_cfg_data;
                CFG_FRAME_HEIGHT: r_fh <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_fw == '0) begin
            w_eff = CWW'(1);
        end else if (CWW'(r_fw) > CWW'(MAX_WIDTH)) begin
            w_eff = CWW'(MAX_WIDTH);
        end else begin
            w_eff = CWW'(r_fw);
        end
        if (r_fh == '0) begin
            h_eff = CHW'(1);
        end else if (CHW'(r_fh) > CHW'(MAX_HEIGHT)) begin
            h_eff = CHW'(MAX_HEIGHT);
        end else begin
            h_eff = CHW'(r_fh);
        end
    end

    assign last_col = (CWW'(r_col) + CWW'(1)) >= w_eff;
    assign last_row = (CHW'(r_row) + CHW'(1)) >= h_eff;
    assign rs_cur   = r_rs + RSW'(i_pix);
    assign push     = i_pix_valid && !i_q_full;

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        n_rs  = r_rs;
        if (push) begin
            if (last_col) begin
                n_col = '0;
                n_rs  = '0;
                n_row = last_row ? '0 : r_row + RW'(1);
            end else begin
                n_col = r_col + CW'(1);
                n_rs  = rs_cur;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_rs  <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            r_rs  <= n_rs;
        end
    end

    assign o_pix_ready       = !i_q_full;
    assign o_push            = push;
    assign o_rs              = rs_cur;
    assign o_col             = r_col;
    assign o_flags.row_zero  = (r_row == '0);
    assign o_flags.row_end   = last_col;
    assign o_flags.frame_end = last_col && last_row;
endmodule

/* hw/rtl/iis_queue.sv */
`timescale 1ns / 1ps

module iis_queue #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_valid,
    output logic [DATA_W-1:0] o_data
);
    localparam int AW = $clog2(DEPTH);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [AW-1:0]     r_wp, r_rp;
    logic [AW:0]       r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + AW'(1);
            end
            if (i_pop) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + AW'(1);
            end
            r_cnt <= r_cnt + (AW+1)'(i_push) - (AW+1)'(i_pop);
        end
    end

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
endmodule

/* hw/rtl/iis_back.sv */
`timescale 1ns / 1ps

module iis_back #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int PIXEL_BITS = 8,
    parameter int CW         = $clog2(MAX_WIDTH),
    parameter int RSW        = CW + PIXEL_BITS
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  logic [RSW-1:0]  i_rs,
    input  logic [CW-1:0]   i_col,
    input  iis_pkg::t_flags i_flags,
    output logic            o_pop,
    iis_sum_if.source       o_sum
);
    import iis_pkg::*;

    localparam int RW   = $clog2(MAX_HEIGHT);
    localparam int SUMW = CW + RW + PIXEL_BITS;

    logic [SUMW-1:0] r_line [MAX_WIDTH];

    logic            r_b1_valid;
    logic [RSW-1:0]  r_b1_rs;
    logic [CW-1:0]   r_b1_col;
    t_flags          r_b1_flags;
    logic [SUMW-1:0] r_rd;
    logic            r_byp;
    logic [SUMW-1:0] r_byp_data;

    logic                r_out_valid;
    logic [SUM_BITS-1:0] r_out_sum;
    logic                r_out_row_end;
    logic                r_out_frame_end;

    logic            out_free, b1_adv, b1_load;
    logic [SUMW-1:0] above, total;

    assign out_free = !r_out_valid || o_sum.ready;
    assign b1_adv   = r_b1_valid && out_free;
    assign b1_load  = i_q_valid && (!r_b1_valid || out_free);

    assign above = r_b1_flags.row_zero ? '0 : (r_byp ? r_byp_data : r_rd);
    assign total = SUMW'(r_b1_rs) + above;

    // line buffer: write on retire, read on load; same-column write forwarded
    always_ff @(posedge i_clk) begin
        if (b1_adv) begin
            r_line[r_b1_col] <= total;
        end
        if (b1_load) begin
            r_rd       <= r_line[i_col];
            r_byp      <= b1_adv && (r_b1_col == i_col);
            r_byp_data <= total;
            r_b1_rs    <= i_rs;
            r_b1_col   <= i_col;
            r_b1_flags <= i_flags;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b1_adv) begin
            r_out_sum       <= SUM_BITS'(total);
            r_out_row_end   <= r_b1_flags.row_end;
            r_out_frame_end <= r_b1_flags.frame_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (b1_load) begin
                r_b1_valid <= 1'b1;
            end else if (b1_adv) begin
                r_b1_valid <= 1'b0;
            end
            if (out_free) begin
                r_out_valid <= r_b1_valid;
            end
        end
    end

    assign o_pop              = b1_load;
    assign o_sum.valid        = r_out_valid;
    assign o_sum.integral_sum = r_out_sum;
    assign o_sum.row_end      = r_out_row_end;
    assign o_sum.frame_end    = r_out_frame_end;
endmodule

/* hw/rtl/integral_image_stream.sv */
`timescale 1ns / 1ps

// Streaming integral image. Pixels enter in raster order, one beat per clock
// while the queue has room, and each produces one beat carrying the sum of
// all pixels at or above-left of it, with row_end and frame_end flags. That
// rate is set by the single add and the one-read/one-write line buffer of
// MAX_WIDTH words. An accepted beat is written into the queue, then loaded
// with its line-buffer read, then held in the output register, which raises
// output valid. A four-entry queue between the counter front end and the
// line-buffer back end absorbs output stalls.
// Frame size is taken from the frame_width/frame_height registers; 0 acts as
// 1 and values above MAX_WIDTH/MAX_HEIGHT are clamped. Write them only while
// the block is idle. Line-buffer contents are undefined after reset; row zero
// never uses them.
module integral_image_stream #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int PIXEL_BITS = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  iis_pkg::t_cfg_idx             i_cfg_idx,
    input  logic [iis_pkg::CFG_BITS-1:0]  i_cfg_data,
    iis_pix_if.sink                       i_pix,
    iis_sum_if.source                     o_sum
);
    import iis_pkg::*;

    localparam int CW     = $clog2(MAX_WIDTH);
    localparam int RSW    = CW + PIXEL_BITS;
    localparam int FLW    = $bits(t_flags);
    localparam int DATA_W = RSW + CW + FLW;

    logic              q_full, q_valid, push, pop;
    logic [RSW-1:0]    f_rs, b_rs;
    logic [CW-1:0]     f_col, b_col;
    t_flags            f_flags, b_flags;
    logic [DATA_W-1:0] q_out;

    iis_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT),
        .PIXEL_BITS(PIXEL_BITS),
        .CW        (CW),
        .RSW       (RSW)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pix_valid(i_pix.valid),
        .i_pix      (i_pix.pixel),
        .i_q_full   (q_full),
        .o_pix_ready(i_pix.ready),
        .o_push     (push),
        .o_rs       (f_rs),
        .o_col      (f_col),
        .o_flags    (f_flags)
    );

    iis_queue #(
        .DATA_W(DATA_W),
        .DEPTH (4)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_data ({f_rs, f_col, f_flags}),
        .i_pop  (pop),
        .o_full (q_full),
        .o_valid(q_valid),
        .o_data (q_out)
    );

    assign {b_rs, b_col, b_flags} = q_out;

    iis_back #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT),
        .PIXEL_BITS(PIXEL_BITS),
        .CW        (CW),
        .RSW       (RSW)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_valid(q_valid),
        .i_rs     (b_rs),
        .i_col    (b_col),
        .i_flags  (b_flags),
        .o_pop    (pop),
        .o_sum    (o_sum)
    );
endmodule

/* hw/rtl/iis_checker.sv */
`timescale 1ns / 1ps

module iis_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic [iis_pkg::SUM_BITS-1:0] i_out_sum,
    input logic                         i_out_row_end,
    input logic                         i_out_frame_end
);
    import iis_pkg::*;

    // frame end is always also a row end
    a_frame_end_row_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_frame_end) |-> i_out_row_end)
        else $error("frame_end without row_end");

    // nothing comes out right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // a stalled beat keeps its payload
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_sum) && $stable(i_out_row_end)
             && $stable(i_out_frame_end)))
        else $error("output beat changed while stalled");
endmodule

bind integral_image_stream iis_checker u_iis_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_sum.valid),
    .i_out_ready    (o_sum.ready),
    .i_out_sum      (o_sum.integral_sum),
    .i_out_row_end  (o_sum.row_end),
    .i_out_frame_end(o_sum.frame_end)
);

/* bench/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import iis_pkg::*;

    localparam int MAX_W         = 1024;
    localparam int MAX_H         = 1024;
    localparam int RANDOM_PIXELS = 400;

    typedef struct {
        logic [SUM_BITS-1:0] integral_sum;
        logic                row_end;
        logic                frame_end;
    } t_sum_beat;

    logic                i_clk    = 1'b0;
    logic                i_rst_n  = 1'b0;
    logic                cfg_we   = 1'b0;
    t_cfg_idx            cfg_idx  = CFG_FRAME_WIDTH;
    logic [CFG_BITS-1:0] cfg_data = '0;

    iis_pix_if #(.PIXEL_BITS(8)) pix_if ();
    iis_sum_if                   sum_if ();

    integral_image_stream #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H),
        .PIXEL_BITS (8)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_pix      (pix_if),
        .o_sum      (sum_if)
    );

    always #10 i_clk = ~i_clk;

    // summed-area predictor state
    logic [CFG_BITS-1:0] width_reg  = CFG_SIZE_RESET;
    logic [CFG_BITS-1:0] height_reg = CFG_SIZE_RESET;
    int                  col_idx    = 0;
    int                  row_idx    = 0;
    logic [SUM_BITS-1:0] row_sum    = '0;
    logic [SUM_BITS-1:0] line_sums [MAX_W];
    bit                  line_written [MAX_W];

    logic [7:0] pixels_pending [$];
    t_sum_beat  sums_due [$];
    bit         pix_taken         = 1'b0;
    int         errors            = 0;
    int         sender_idle_pct   = 32;
    int         receiver_idle_pct = 77;
    int         random_sent       = 0;

    function automatic int clamp_size(logic [CFG_BITS-1:0] v, int limit);
        if (v == 0) return 1;
        if (v > limit) return limit;
        return v;
    endfunction

    task automatic integrate_pixel(input logic [7:0] pix);
        int                  w;
        int                  h;
        logic [SUM_BITS-1:0] above;
        t_sum_beat           beat;
        w = clamp_size(width_reg, MAX_W);
        h = clamp_size(height_reg, MAX_H);
        if (col_idx == 0) row_sum = '0;
        row_sum = row_sum + SUM_BITS'(pix);
        above = (row_idx == 0) ? '0 : line_sums[col_idx];
        beat.integral_sum = row_sum + above;
        line_sums[col_idx] = beat.integral_sum;
        line_written[col_idx] = 1'b1;
        beat.row_end = (col_idx + 1 >= w);
        beat.frame_end = beat.row_end && (row_idx + 1 >= h);
        sums_due = {sums_due, beat};
        if (beat.row_end) begin
            col_idx = 0;
            row_sum = '0;
            row_idx = beat.frame_end ? 0 : row_idx + 1;
        end else begin
            col_idx = col_idx + 1;
        end
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    task automatic check_sum_beat();
        t_sum_beat want;
        if (sums_due.size() == 0) begin
            report_mismatch("beat with nothing pending", 32'(sum_if.integral_sum), 32'd0);
            return;
        end
        want = sums_due.pop_front();
        if (sum_if.integral_sum !== want.integral_sum)
            report_mismatch("integral_sum", 32'(sum_if.integral_sum),
                            32'(want.integral_sum));
        if (sum_if.row_end !== want.row_end)
            report_mismatch("row_end", 32'(sum_if.row_end), 32'(want.row_end));
        if (sum_if.frame_end !== want.frame_end)
            report_mismatch("frame_end", 32'(sum_if.frame_end), 32'(want.frame_end));
    endtask

    // growing the width while in a row above zero must only reach written columns
    function automatic bit width_is_safe(logic [CFG_BITS-1:0] w);
        int last;
        if (row_idx == 0) return 1'b1;
        last = clamp_size(w, MAX_W) - 1;
        if (last < col_idx) last = col_idx;
        for (int j = col_idx; j <= last; j++)
            if (!line_written[j]) return 1'b0;
        return 1'b1;
    endfunction

    function automatic logic [7:0] rand_pixel();
        case ($urandom_range(0, 7))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic wait_idle();
        do @(negedge i_clk);
        while (pixels_pending.size() != 0 || sums_due.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic set_frame(input logic [CFG_BITS-1:0] w, input logic [CFG_BITS-1:0] h);
        wait_idle();
        if (!width_is_safe(w)) w = width_reg;
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_FRAME_WIDTH;
        cfg_data <= w;
        @(negedge i_clk);
        cfg_idx  <= CFG_FRAME_HEIGHT;
        cfg_data <= h;
        @(negedge i_clk);
        cfg_we   <= 1'b0;
    endtask

    task automatic push_fixed(input int n, input logic [7:0] value);
        repeat (n) pixels_pending = {pixels_pending, value};
    endtask

    task automatic push_random(input int n);
        repeat (n) begin
            pixels_pending = {pixels_pending, rand_pixel()};
            random_sent++;
        end
    endtask

    always @(posedge i_clk) begin
        pix_taken = pix_if.valid && pix_if.ready;
        if (!i_rst_n) begin
            width_reg  = CFG_SIZE_RESET;
            height_reg = CFG_SIZE_RESET;
            col_idx    = 0;
            row_idx    = 0;
            row_sum    = '0;
            foreach (line_written[j]) line_written[j] = 1'b0;
        end else begin
            if (cfg_we) begin
                if (cfg_idx == CFG_FRAME_WIDTH) width_reg = cfg_data;
                else height_reg = cfg_data;
            end
            if (pix_taken) begin
                integrate_pixel(pix_if.pixel);
                void'(pixels_pending.pop_front());
            end
            if (sum_if.valid && sum_if.ready) check_sum_beat();
        end
    end

    // pixel driver and result receiver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            pix_if.valid <= 1'b0;
            sum_if.ready <= 1'b0;
        end else begin
            if (!pix_if.valid || pix_taken) begin
                if (pixels_pending.size() != 0 &&
                    $urandom_range(0, 99) >= sender_idle_pct) begin
                    pix_if.valid <= 1'b1;
                    pix_if.pixel <= pixels_pending[0];
                end else begin
                    pix_if.valid <= 1'b0;
                end
            end
            sum_if.ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
        end
    end

    initial begin
        int w;
        int h;
        pix_if.valid = 1'b0;
        pix_if.pixel = '0;
        sum_if.ready = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset size, then shrink in the middle of row zero
        push_fixed(1, 8'd255);
        push_fixed(1, 8'd0);
        push_fixed(1, 8'd1);
        set_frame(11'd2, 11'd0);
        push_fixed(1, 8'd170);
        push_fixed(1, 8'd85);
        push_fixed(1, 8'd255);
        set_frame(11'd0, 11'd0);
        push_fixed(1, 8'd255);
        push_fixed(1, 8'd0);
        set_frame(11'd3, 11'd3);
        push_random(4);
        set_frame(11'd2, 11'd3);
        push_random(1);
        set_frame(11'd2, 11'd1);
        push_random(2);
        set_frame(11'd1, 11'd4);
        push_random(2);
        set_frame(11'd3, 11'd4);
        push_random(6);

        // oversize and full-size registers
        set_frame(11'd2047, 11'd2047);
        push_random(5);
        set_frame(11'd1024, 11'd1024);
        push_random(5);

        random_sent = 0;
        while (random_sent < RANDOM_PIXELS) begin
            if (random_sent >= 2 * RANDOM_PIXELS / 3) begin
                sender_idle_pct   = 0;
                receiver_idle_pct = 0;
            end else if (random_sent >= RANDOM_PIXELS / 3) begin
                sender_idle_pct   = 77;
                receiver_idle_pct = 32;
            end
            case ($urandom_range(0, 9))
                0:       w = 0;
                1:       w = 1;
                8, 9:    w = $urandom_range(13, 24);
                default: w = $urandom_range(2, 12);
            endcase
            case ($urandom_range(0, 7))
                0:       h = 0;
                1:       h = 1;
                default: h = $urandom_range(2, 6);
            endcase
            set_frame(CFG_BITS'(w), CFG_BITS'(h));
            w = clamp_size(width_reg, MAX_W);
            h = clamp_size(height_reg, MAX_H);
            push_random($urandom_range(1, 2) * w * h);
            if ($urandom_range(0, 2) == 0 && w * h > 1)
                push_random($urandom_range(1, w * h - 1));
        end

        while (pixels_pending.size() != 0 || sums_due.size() != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
